### rtl/sha256_pkg.sv
package sha256_pkg;

    // block geometry
    localparam int unsigned BLOCK_BYTES  = 64;
    localparam int unsigned FILL_W       = 6;
    localparam int unsigned LEN_OFFSET   = 56;
    localparam int unsigned WORD_IDX_W   = 3;
    localparam int unsigned ROUND_W      = 6;

    // padding marker byte
    localparam logic [7:0] PAD_MARK = 8'h80;

    // initial hash value
    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // round constants
    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD80,
        ST_PAD0,
        ST_LEN,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } t_state;

    // source of the byte shifted into the block register
    typedef enum logic [2:0] {
        SH_NONE,
        SH_DATA,
        SH_MARK,
        SH_ZERO,
        SH_LEN
    } t_shift;

    // controller to datapath
    typedef struct packed {
        t_shift shift_sel;
        logic   comp_start;
        logic   round_en;
        logic   cv_add;
        logic   word_next;
        logic   msg_clear;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic fill_last;
        logic fill_at_len;
        logic round_last;
        logic word_last;
    } t_dp_sts;

endpackage

### rtl/sha256_ctrl.sv
module sha256_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_present,
    input  logic                i_in_end,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  sha256_pkg::t_dp_sts i_sts,
    output sha256_pkg::t_dp_cmd o_cmd
);

    sha256_pkg::t_state r_state, n_state;
    sha256_pkg::t_state r_ret, n_ret;
    logic               w_in_xfer;
    logic               w_out_xfer;

    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_out_xfer = o_out_valid && i_out_ready;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha256_pkg::ST_IDLE;
            r_ret   <= sha256_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    // next state and return state after a compression
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        case (r_state)
            sha256_pkg::ST_IDLE: begin
                if (w_in_xfer) begin
                    if (i_in_present && i_sts.fill_last) begin
                        n_state = sha256_pkg::ST_ROUND;
                        n_ret   = i_in_end ? sha256_pkg::ST_PAD80 : sha256_pkg::ST_IDLE;
                    end else if (i_in_end) begin
                        n_state = sha256_pkg::ST_PAD80;
                    end
                end
            end
            sha256_pkg::ST_PAD80: begin
                if (i_sts.fill_last) begin
                    n_state = sha256_pkg::ST_ROUND;
                    n_ret   = sha256_pkg::ST_PAD0;
                end else begin
                    n_state = sha256_pkg::ST_PAD0;
                end
            end
            sha256_pkg::ST_PAD0: begin
                if (i_sts.fill_at_len) begin
                    n_state = sha256_pkg::ST_LEN;
                end else if (i_sts.fill_last) begin
                    n_state = sha256_pkg::ST_ROUND;
                    n_ret   = sha256_pkg::ST_PAD0;
                end
            end
            sha256_pkg::ST_LEN: begin
                if (i_sts.fill_last) begin
                    n_state = sha256_pkg::ST_ROUND;
                    n_ret   = sha256_pkg::ST_OUT;
                end
            end
            sha256_pkg::ST_ROUND: begin
                if (i_sts.round_last) begin
                    n_state = sha256_pkg::ST_FINAL;
                end
            end
            sha256_pkg::ST_FINAL: begin
                n_state = r_ret;
            end
            sha256_pkg::ST_OUT: begin
                if (w_out_xfer && i_sts.word_last) begin
                    n_state = sha256_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sha256_pkg::ST_IDLE;
            end
        endcase
    end

    // commands and handshake outputs
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '{shift_sel: sha256_pkg::SH_NONE, default: 1'b0};
        case (r_state)
            sha256_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && i_in_present) begin
                    o_cmd.shift_sel  = sha256_pkg::SH_DATA;
                    o_cmd.comp_start = i_sts.fill_last;
                end
            end
            sha256_pkg::ST_PAD80: begin
                o_cmd.shift_sel  = sha256_pkg::SH_MARK;
                o_cmd.comp_start = i_sts.fill_last;
            end
            sha256_pkg::ST_PAD0: begin
                if (!i_sts.fill_at_len) begin
                    o_cmd.shift_sel  = sha256_pkg::SH_ZERO;
                    o_cmd.comp_start = i_sts.fill_last;
                end
            end
            sha256_pkg::ST_LEN: begin
                o_cmd.shift_sel  = sha256_pkg::SH_LEN;
                o_cmd.comp_start = i_sts.fill_last;
            end
            sha256_pkg::ST_ROUND: begin
                o_cmd.round_en = 1'b1;
            end
            sha256_pkg::ST_FINAL: begin
                o_cmd.cv_add = 1'b1;
            end
            sha256_pkg::ST_OUT: begin
                o_out_valid     = 1'b1;
                o_cmd.word_next = i_out_ready;
                o_cmd.msg_clear = i_out_ready && i_sts.word_last;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/sha256_dp.sv
module sha256_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_data_byte,
    input  sha256_pkg::t_dp_cmd i_cmd,
    output sha256_pkg::t_dp_sts o_sts,
    output logic [31:0]         o_digest_word,
    output logic [2:0]          o_word_number,
    output logic                o_last_word,
    output logic                o_length_error
);

    localparam logic [sha256_pkg::FILL_W-1:0] FILL_LAST =
        sha256_pkg::FILL_W'(sha256_pkg::BLOCK_BYTES - 1);
    localparam logic [sha256_pkg::FILL_W-1:0] FILL_LEN =
        sha256_pkg::FILL_W'(sha256_pkg::LEN_OFFSET);

    // small sigma and big sigma functions
    function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

    logic [511:0]                  r_blk;
    logic [sha256_pkg::FILL_W-1:0] r_fill;
    logic [63:0]                   r_count;
    logic                          r_ovf;
    logic [31:0]                   r_cv [8];
    logic [31:0]                   r_v  [8];
    logic [sha256_pkg::ROUND_W-1:0]    r_round;
    logic [sha256_pkg::WORD_IDX_W-1:0] r_word;

    logic [7:0]  w_shift_byte;
    logic [63:0] w_bits;
    logic [2:0]  w_len_sel;
    logic [31:0] w_w0, w_w1, w_w9, w_w14, w_wnew;
    logic [31:0] w_t1, w_t2;
    logic        w_count_max;

    // schedule window taps, word 0 is the oldest
    assign w_w0  = r_blk[511:480];
    assign w_w1  = r_blk[479:448];
    assign w_w9  = r_blk[223:192];
    assign w_w14 = r_blk[63:32];
    assign w_wnew = sig1(w_w14) + w_w9 + sig0(w_w1) + w_w0;

    // length bytes go out most significant first
    assign w_bits    = {r_count[60:0], 3'b000};
    assign w_len_sel = 3'd7 - r_fill[2:0];

    always_comb begin
        case (i_cmd.shift_sel)
            sha256_pkg::SH_DATA: w_shift_byte = i_data_byte;
            sha256_pkg::SH_MARK: w_shift_byte = sha256_pkg::PAD_MARK;
            sha256_pkg::SH_LEN:  w_shift_byte = w_bits[{w_len_sel, 3'b000} +: 8];
            default:             w_shift_byte = 8'h00;
        endcase
    end

    // round function
    assign w_t1 = r_v[7] + bsig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
                + sha256_pkg::ROUND_K[r_round] + w_w0;
    assign w_t2 = bsig0(r_v[0])
                + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    assign w_count_max = (r_count[63:61] != 3'b000) || (&r_count[60:0]);

    // block register: byte shifts while filling, word shifts while compressing
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_sel != sha256_pkg::SH_NONE) begin
            r_blk <= {r_blk[503:0], w_shift_byte};
        end else if (i_cmd.round_en) begin
            r_blk <= {r_blk[479:0], w_wnew};
        end
    end

    // working variables
    always_ff @(posedge i_clk) begin
        if (i_cmd.comp_start) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_cv[i];
        end else if (i_cmd.round_en) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= w_t1 + w_t2;
        end
    end

    // counters, chaining value and length state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_round <= '0;
            r_word  <= '0;
            for (int i = 0; i < 8; i++) r_cv[i] <= sha256_pkg::INIT_HASH[i];
        end else begin
            if (i_cmd.shift_sel != sha256_pkg::SH_NONE) begin
                r_fill <= r_fill + 1'b1;
            end
            if (i_cmd.shift_sel == sha256_pkg::SH_DATA) begin
                r_count <= r_count + 64'd1;
                if (w_count_max) r_ovf <= 1'b1;
            end
            if (i_cmd.comp_start) begin
                r_round <= '0;
            end else if (i_cmd.round_en) begin
                r_round <= r_round + 1'b1;
            end
            if (i_cmd.word_next) begin
                r_word <= r_word + 1'b1;
            end
            if (i_cmd.cv_add) begin
                for (int i = 0; i < 8; i++) r_cv[i] <= r_cv[i] + r_v[i];
            end
            if (i_cmd.msg_clear) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
                for (int i = 0; i < 8; i++) r_cv[i] <= sha256_pkg::INIT_HASH[i];
            end
        end
    end

    // status back to the controller
    assign o_sts.fill_last   = (r_fill == FILL_LAST);
    assign o_sts.fill_at_len = (r_fill == FILL_LEN);
    assign o_sts.round_last  = (&r_round);
    assign o_sts.word_last   = (&r_word);

    // digest readout
    assign o_digest_word  = r_cv[r_word];
    assign o_word_number  = r_word;
    assign o_last_word    = (&r_word);
    assign o_length_error = r_ovf;

endmodule

### rtl/sha256_hash_engine.sv
// channel   | direction | tdata                  | tuser                              | tlast
// ----------+-----------+------------------------+------------------------------------+---------------
// s_axis    | in        | [7:0] data_byte        | [0] byte_present                   | end_of_message
// m_axis    | out       | [31:0] digest_word     | [2:0] word_number, [3] length_error | last_word
//
// message bytes are shifted into the block register; every 64th byte starts a compression
// (64 rounds on one shared round unit, then the chaining add)
// an end item adds the padding and length bytes plus one or two compressions
// one item at a time: s_axis_tready is low during compression, padding and digest readout
// the eight digest words hold on m_axis while m_axis_tready is low
// synchronous active-low reset loads the initial hash value and clears all counters
module sha256_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] byte_present
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [3:0]  m_axis_tuser,   // [2:0] word_number, [3] length_error
    output logic        m_axis_tlast
);

    sha256_pkg::t_dp_cmd w_cmd;
    sha256_pkg::t_dp_sts w_sts;
    logic [2:0]          w_word_number;
    logic                w_length_error;

    // sequencer
    sha256_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_present (s_axis_tuser),
        .i_in_end     (s_axis_tlast),
        .o_in_ready   (s_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_sts        (w_sts),
        .o_cmd        (w_cmd)
    );

    // block register, round unit and chaining value
    sha256_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_data_byte    (s_axis_tdata),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_digest_word  (m_axis_tdata),
        .o_word_number  (w_word_number),
        .o_last_word    (m_axis_tlast),
        .o_length_error (w_length_error)
    );

    // output sideband packing
    assign m_axis_tuser = {w_length_error, w_word_number};

endmodule

### test/tb_sha256_hash_engine.sv
`timescale 1ns / 100ps

module tb_sha256_hash_engine;

    // run limits
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 160;

    // hash constants kept apart from the rtl package
    localparam logic [31:0] H0_TAB [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // digest of the empty message
    localparam logic [255:0] EMPTY_DIGEST =
        256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;

    localparam logic [63:0] MAX_MSG_BYTES = 64'h1FFF_FFFF_FFFF_FFFF;

    // one expected digest word
    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        is_last;
        logic        err;
    } t_digest_out;

    // one row of the directed table
    typedef struct packed {
        logic [7:0]   data;
        logic         present;
        logic         eom;
        logic         known;
        logic [255:0] digest;
    } t_stim_row;

    // dut ports
    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic        s_axis_tuser = 1'b0;    // [0] byte_present
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [31:0] digest_word
    logic [3:0]  m_axis_tuser;           // [2:0] word_number, [3] length_error
    logic        m_axis_tlast;

    // predictor state
    logic [31:0] chain_hv [8];
    logic [7:0]  blk_buf [64];
    int          fill_cnt;
    logic [63:0] byte_total;
    logic        len_ovf;

    t_digest_out digest_q [$];

    // bookkeeping
    int err_cnt = 0;
    int items_sent = 0;
    int msgs_done = 0;
    int words_checked = 0;
    int cycle_cnt = 0;
    int tx_pct = 21;
    int rx_pct = 63;

    t_stim_row dir_tab [15];

    sha256_hash_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // back to the initial hash value with an empty block
    function automatic void hash_clear();
        chain_hv = H0_TAB;
        for (int i = 0; i < 64; i++) blk_buf[i] = 8'h00;
        fill_cnt = 0;
        byte_total = '0;
        len_ovf = 1'b0;
    endfunction

    // 64-round compression of blk_buf into chain_hv
    function automatic void compress_blk();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        v = chain_hv;
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain_hv[i] += v[i];
    endfunction

    // absorb one accepted transfer, queue the digest on end of message
    function automatic void hash_accept(input logic [7:0] d, input logic p, input logic l,
                                        input logic known, input logic [255:0] typed);
        logic [63:0] bits;
        t_digest_out o;
        if (p) begin
            blk_buf[fill_cnt] = d;
            fill_cnt++;
            if (byte_total >= MAX_MSG_BYTES) len_ovf = 1'b1;
            byte_total++;
            if (fill_cnt == 64) begin
                compress_blk();
                fill_cnt = 0;
            end
        end
        if (l) begin
            bits = byte_total << 3;
            blk_buf[fill_cnt] = 8'h80;
            fill_cnt++;
            // no room for the length field, pad out an extra block
            if (fill_cnt > 56) begin
                for (int i = fill_cnt; i < 64; i++) blk_buf[i] = 8'h00;
                compress_blk();
                fill_cnt = 0;
            end
            for (int i = fill_cnt; i < 56; i++) blk_buf[i] = 8'h00;
            for (int i = 0; i < 8; i++) blk_buf[63-i] = bits[8*i +: 8];
            compress_blk();
            for (int k = 0; k < 8; k++) begin
                o.word    = known ? typed[255 - 32*k -: 32] : chain_hv[k];
                o.idx     = 3'(k);
                o.is_last = (k == 7);
                o.err     = len_ovf;
                digest_q.insert(digest_q.size(), o);
            end
            hash_clear();
        end
    endfunction

    // one transfer on the slave side, with random idle cycles ahead of it
    task automatic send_item(input logic [7:0] d, input logic p, input logic l,
                             input logic known = 1'b0, input logic [255:0] typed = '0);
        while ($urandom_range(99) < tx_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= p;
        s_axis_tlast  <= l;
        do @(posedge i_clk); while (!s_axis_tready);
        hash_accept(d, p, l, known, typed);
        if (p || l) begin
            items_sent++;
            // idle profile: sender light, then receiver light, then none
            if (items_sent == 75) begin
                tx_pct = 63;
                rx_pct = 21;
            end else if (items_sent == 150) begin
                tx_pct = 0;
                rx_pct = 0;
            end
        end
        if (l) msgs_done++;
    endtask

    // hold the sender off until every queued digest word has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (digest_q.size() != 0) @(posedge i_clk);
    endtask

    // a whole message of random bytes with the odd empty item mixed in
    task automatic send_message(input int len, input bit end_on_byte);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(19) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(255)), 1'b1, end_on_byte && (k == len - 1));
        end
        if (!end_on_byte || len == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    // receiver backpressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_pct);
    end

    // compare each master-side transfer with the oldest expected word
    always @(posedge i_clk) begin : check_out
        t_digest_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (digest_q.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected digest word: expected none, actual %h idx %0d",
                         $time, m_axis_tdata, m_axis_tuser[2:0]);
            end else begin
                want = digest_q.pop_front();
                words_checked++;
                if (m_axis_tdata !== want.word) begin
                    err_cnt++;
                    $display("%0t: digest_word mismatch: expected %h, actual %h",
                             $time, want.word, m_axis_tdata);
                end
                if (m_axis_tuser[2:0] !== want.idx) begin
                    err_cnt++;
                    $display("%0t: word_number mismatch: expected %0d, actual %0d",
                             $time, want.idx, m_axis_tuser[2:0]);
                end
                if (m_axis_tlast !== want.is_last) begin
                    err_cnt++;
                    $display("%0t: last_word mismatch: expected %b, actual %b",
                             $time, want.is_last, m_axis_tlast);
                end
                if (m_axis_tuser[3] !== want.err) begin
                    err_cnt++;
                    $display("%0t: length_error mismatch: expected %b, actual %b",
                             $time, want.err, m_axis_tuser[3]);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d digest words outstanding", $time, digest_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // main sequence
    initial begin
        // data, byte_present, end_of_message, typed digest flag, typed digest
        dir_tab = '{
            '{8'hA5, 1'b0, 1'b0, 1'b0, 256'h0},          // empty item is ignored
            '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},    // empty message after reset
            '{8'h00, 1'b1, 1'b1, 1'b0, 256'h0},          // single zero byte ending the message
            '{8'hFF, 1'b1, 1'b1, 1'b0, 256'h0},          // single all-ones byte
            '{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
            '{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
            '{8'h3C, 1'b0, 1'b0, 1'b0, 256'h0},          // empty item inside a message
            '{8'h63, 1'b1, 1'b1, 1'b0, 256'h0},
            '{8'hFF, 1'b1, 1'b0, 1'b0, 256'h0},
            '{8'h00, 1'b1, 1'b0, 1'b0, 256'h0},
            '{8'h80, 1'b1, 1'b0, 1'b0, 256'h0},
            '{8'h5A, 1'b0, 1'b1, 1'b0, 256'h0},          // end item with no byte
            '{8'hFF, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},    // empty message, data ignored
            '{8'h00, 1'b0, 1'b0, 1'b0, 256'h0},
            '{8'h7F, 1'b1, 1'b1, 1'b0, 256'h0}
        };
        hash_clear();

        // reset
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        foreach (dir_tab[r])
            send_item(dir_tab[r].data, dir_tab[r].present, dir_tab[r].eom,
                      dir_tab[r].known, dir_tab[r].digest);
        wait_drained();

        // padding boundaries: length just fits, length spills, exact block
        send_message(55, 1'b0);
        send_message(56, 1'b1);
        send_message(64, 1'($urandom_range(1)));

        // short random messages
        while (items_sent < 180 || msgs_done < 11) begin
            if ($urandom_range(3) == 0) wait_drained();
            send_message($urandom_range(0, 16), 1'($urandom_range(1)));
        end

        // let the last digest out, then watch for stray words
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (digest_q.size() != 0) begin
            err_cnt++;
            $display("%0t: %0d digest words never arrived", $time, digest_q.size());
        end

        $display("covered %0d messages from %0d byte and end items, %0d digest words checked",
                 msgs_done, items_sent, words_checked);
        $display("including empty messages, padding spill into an extra block and idle mixes");
        if (err_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
